@@ rtl/core/rct_pkg.sv @@
// Shared types and constants for the reference count table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rct_pkg;

   localparam int KEY_W    = 64;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Operation codes
   localparam logic OP_ADD     = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Request word broadcast to all cells during a walk
   typedef struct packed {
      logic             opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   // Token handed from cell to cell
   typedef struct packed {
      logic               active;
      logic               hit;
      logic               free_seen;
      logic               freed;
      logic [COUNT_W-1:0] count;
   } tok_type;

endpackage : rct_pkg

`default_nettype wire

@@ rtl/core/rct_cell.sv @@
// One table slot: key, count and valid bit, plus the token stage of the chain.
// Depends on rct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rct_cell
   import rct_pkg::*;
#(
   parameter int IDX_W = 5,
   parameter int INDEX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_type          req,
   input  wire logic             free_on_zero,
   input  wire logic             claim,
   input  wire tok_type          tok_in,
   input  wire logic [IDX_W-1:0] free_idx_in,
   output tok_type               tok_out,
   output logic      [IDX_W-1:0] free_idx_out
);

   logic               valid_ff, valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   tok_type            tok_ff, tok_in_next;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in_next;
   logic               match;
   logic [COUNT_W-1:0] new_count;

   always_comb begin
      match            = valid_ff && (key_ff == req.key);
      valid_in         = valid_ff;
      count_in         = count_ff;
      key_in           = key_ff;
      tok_in_next      = tok_in;
      free_idx_in_next = free_idx_in;
      new_count        = count_ff;

      if (tok_in.active && match) begin
         tok_in_next.hit = 1'b1;
         if (req.opcode == OP_ADD) begin
            new_count = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
            count_in  = new_count;
         end else begin
            new_count = (count_ff == '0) ? count_ff : count_ff - 1'b1;
            count_in  = new_count;
            if (new_count == '0 && free_on_zero) begin
               valid_in          = 1'b0;
               tok_in_next.freed = 1'b1;
            end
         end
         tok_in_next.count = new_count;
      end else if (tok_in.active && !valid_ff && !tok_in.free_seen) begin
         // first free slot seen on this walk
         tok_in_next.free_seen = 1'b1;
         free_idx_in_next      = IDX_W'(INDEX);
      end

      if (claim) begin
         valid_in = 1'b1;
         key_in   = req.key;
         count_in = COUNT_W'(1);
      end
   end

   // only the valid bit, the count and the token marker are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         count_ff      <= '0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         tok_ff.active <= tok_in_next.active;
      end
      key_ff           <= key_in;
      tok_ff.hit       <= tok_in_next.hit;
      tok_ff.free_seen <= tok_in_next.free_seen;
      tok_ff.freed     <= tok_in_next.freed;
      tok_ff.count     <= tok_in_next.count;
      free_idx_ff      <= free_idx_in_next;
   end

   assign tok_out      = tok_ff;
   assign free_idx_out = free_idx_ff;

endmodule : rct_cell

`default_nettype wire

@@ rtl/core/reference_count_table.sv @@
// Reference count table: associative key/count slots built as a chain of cells.
// An accepted start launches a token that walks the chain one cell per cycle;
// busy holds off a new word until it leaves the last cell. Results are registered
// with the rsp_valid strobe. The receiver cannot stall; results are never held.
// Reset (synchronous, active high) empties every slot and sets free_on_zero.
// Depends on rct_pkg and rct_cell.
`timescale 1ns / 1ps
`default_nettype none

module reference_count_table
   import rct_pkg::*;
#(
   parameter int ENTRIES = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request word
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_opcode,
   input  wire logic [KEY_W-1:0]    req_key,
   // response word
   output logic                     rsp_valid,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_freed,
   // control register
   input  wire logic                csr_write_enable,
   input  wire logic                csr_write_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Request held for the whole walk and broadcast to all cells
   req_type req_ff;
   logic    free_on_zero_ff;
   logic    busy_ff, busy_in;
   logic    launch_ff;
   logic    accept;

   // Token chain: stage 0 is the launch, stage ENTRIES is the last cell's output
   tok_type          chain_tok [ENTRIES+1];
   logic [IDX_W-1:0] chain_idx [ENTRIES+1];
   logic [ENTRIES-1:0] cell_claim;

   // Response registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_freed_ff, rsp_freed_in;
   logic                claim;
   tok_type             done_tok;

   assign accept = start && !busy_ff;

   assign chain_tok[0] = '{active: launch_ff, hit: 1'b0, free_seen: 1'b0, freed: 1'b0,
                           count: '0};
   assign chain_idx[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         assign cell_claim[gi] = claim && (chain_idx[ENTRIES] == IDX_W'(gi));

         rct_cell #(
            .IDX_W (IDX_W),
            .INDEX (gi)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .req          (req_ff),
            .free_on_zero (free_on_zero_ff),
            .claim        (cell_claim[gi]),
            .tok_in       (chain_tok[gi]),
            .free_idx_in  (chain_idx[gi]),
            .tok_out      (chain_tok[gi+1]),
            .free_idx_out (chain_idx[gi+1])
         );
      end
   endgenerate

   // Token leaving the last cell closes the walk. A hit was already applied
   // in its cell; a missed add claims the lowest free slot seen on the way.
   always_comb begin
      done_tok      = chain_tok[ENTRIES];
      rsp_valid_in  = done_tok.active;
      rsp_count_in  = '0;
      rsp_status_in = STATUS_OK;
      rsp_freed_in  = 1'b0;
      claim         = 1'b0;
      if (done_tok.hit) begin
         rsp_count_in = done_tok.count;
         rsp_freed_in = done_tok.freed;
      end else if (req_ff.opcode == OP_ADD) begin
         if (done_tok.free_seen) begin
            claim        = done_tok.active;
            rsp_count_in = COUNT_W'(1);
         end else begin
            rsp_status_in = STATUS_FULL;
         end
      end else begin
         rsp_status_in = STATUS_NOT_FOUND;
      end

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done_tok.active) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         launch_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         free_on_zero_ff <= 1'b1;
      end else begin
         busy_ff      <= busy_in;
         launch_ff    <= accept;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            free_on_zero_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.opcode <= req_opcode;
         req_ff.key    <= req_key;
      end
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_freed  = rsp_freed_ff;

endmodule : reference_count_table

`default_nettype wire

@@ rtl/core/rct_checker.sv @@
// Port-level checks for reference_count_table, bound to the top level.
// Depends on rct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rct_checker
   import rct_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic [COUNT_W-1:0]  rsp_count,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                rsp_freed
);

   // accepted word keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // response comes as the walk ends
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // one response per word
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response repeated");

   // freed only on a successful release to zero
   a_freed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_freed |-> rsp_status == STATUS_OK && rsp_count == '0)
      else $error("freed with nonzero count or error status");

   // errors report a zero count
   a_err_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_count == '0 && !rsp_freed)
      else $error("error response with count");

endmodule : rct_checker

bind reference_count_table rct_checker u_rct_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_count  (rsp_count),
   .rsp_status (rsp_status),
   .rsp_freed  (rsp_freed)
);

`default_nettype wire
